@@ hdl/tma_pkg.sv @@
// ----------------------------------------------------------------------------
// tma_pkg
// Types, constants and binary32 arithmetic helpers for the transfer matrix
// accumulator.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_ZERO     = 32'h0000_0000;
  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [63:0] ONE_PACKED = {F_ONE, F_ZERO};

  localparam logic OP_IDENT = 1'b0;
  localparam logic OP_MUL   = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // binary32 multiply, round to nearest even, subnormals kept
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, sr;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] pr;
    logic [5:0]  lza, lzb;
    logic signed [11:0] ex;
    logic [49:0] sh;
    logic [5:0]  rs;
    logic        st, g;
    logic [24:0] mr;
    logic        anan, bnan, ainf, binf, az, bz;
    logic [31:0] r;
    sa = a[31]; sb = b[31]; sr = sa ^ sb;
    ea = a[30:23]; eb = b[30:23];
    anan = (ea == 8'hFF) && (a[22:0] != 0);
    bnan = (eb == 8'hFF) && (b[22:0] != 0);
    ainf = (ea == 8'hFF) && (a[22:0] == 0);
    binf = (eb == 8'hFF) && (b[22:0] == 0);
    az = (a[30:0] == 0); bz = (b[30:0] == 0);
    ma = {(ea != 0), a[22:0]};
    mb = {(eb != 0), b[22:0]};
    lza = 0; lzb = 0;
    for (int i = 23; i >= 0; i--) begin
      if (ma[i] && lza == 0 && ma[23:0] >> (i + 1) == 0) lza = 6'(23 - i);
      if (mb[i] && lzb == 0 && mb[23:0] >> (i + 1) == 0) lzb = 6'(23 - i);
    end
    ma = ma << lza; mb = mb << lzb;
    ex = $signed({4'd0, (ea == 0) ? 8'd1 : ea}) + $signed({4'd0, (eb == 0) ? 8'd1 : eb})
         - 12'sd127 - $signed({6'd0, lza}) - $signed({6'd0, lzb});
    pr = ma * mb;
    if (pr[47]) ex = ex + 12'sd1;
    else pr = pr << 1;
    // pr[47] leading one; keep 24 bits + round
    sh = {pr, 2'b00};
    st = 1'b0;
    if (ex < 12'sd1) begin
      // subnormal result: one aligning shift, shifted-out bits go to sticky
      rs = (ex < -12'sd48) ? 6'd50 : 6'(12'sd1 - ex);
      st = (sh & ((50'd1 << rs) - 50'd1)) != 0;
      sh = sh >> rs;
      ex = 12'sd0;
    end
    g  = sh[25];
    st = st | (sh[24:0] != 0);
    mr = {1'b0, sh[49:26]};
    if (g && (st || mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      ex = ex + 12'sd1;
    end else if (ex == 0 && mr[23]) ex = 12'sd1;
    if (anan || bnan || (ainf && bz) || (binf && az)) r = CANON_NAN;
    else if (ainf || binf) r = {sr, 8'hFF, 23'd0};
    else if (az || bz) r = {sr, 31'd0};
    else if (ex >= 12'sd255) r = {sr, 8'hFF, 23'd0};
    else r = {sr, ex[7:0], mr[22:0]};
    return r;
  endfunction

  // binary32 add, round to nearest even
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb, el;
    logic [26:0] ma, mb, mt;
    logic        sa, sb, sr, st;
    logic [7:0]  d;
    logic [27:0] s;
    logic signed [10:0] ex;
    logic [4:0]  lz;
    logic [7:0]  na;
    logic [24:0] mr;
    logic        anan, bnan, ainf, binf;
    logic [31:0] r;
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    anan = (ea == 8'hFF) && (a[22:0] != 0);
    bnan = (eb == 8'hFF) && (b[22:0] != 0);
    ainf = (ea == 8'hFF) && (a[22:0] == 0);
    binf = (eb == 8'hFF) && (b[22:0] == 0);
    ma = {(ea != 0), a[22:0], 3'b000};
    mb = {(eb != 0), b[22:0], 3'b000};
    if (ea == 0) ea = 8'd1;
    if (eb == 0) eb = 8'd1;
    if ({ea, ma} < {eb, mb}) begin
      mt = ma; ma = mb; mb = mt;
      el = ea; ea = eb; eb = el;
      sr = sa; sa = sb; sb = sr;
    end
    d = ea - eb;
    if (d >= 8'd27) begin
      st = (mb != 0);
      mb = '0;
    end else begin
      st = (mb & ((27'd1 << d) - 27'd1)) != 0;
      mb = mb >> d;
    end
    mb[0] = mb[0] | st;
    if (sa == sb) s = {1'b0, ma} + {1'b0, mb};
    else s = {1'b0, ma} - {1'b0, mb};
    ex = {3'd0, ea};
    if (s[27]) begin
      s = {1'b0, s[27:2], s[1] | s[0]};
      ex = ex + 11'sd1;
    end else begin
      // leading zero count, shift limited so the exponent stays >= 1
      lz = 5'd27;
      for (int k = 0; k < 27; k++) begin
        if (s[k]) lz = 5'(26 - k);
      end
      if (ex - 11'sd1 < $signed({6'd0, lz})) na = 8'(ex - 11'sd1);
      else na = {3'd0, lz};
      s = s << na;
      ex = ex - $signed({3'd0, na});
      if (!s[26]) ex = 11'sd0;
    end
    mr = {1'b0, s[26:3]};
    if (s[2] && (s[1] || s[0] || mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      ex = ex + 11'sd1;
    end else if (ex == 0 && mr[23]) ex = 11'sd1;
    if (anan || bnan || (ainf && binf && (a[31] != b[31]))) r = CANON_NAN;
    else if (ainf) r = a;
    else if (binf) r = b;
    else if (s == 0) r = {a[31] & b[31], 31'd0};
    else if (ex >= 11'sd255) r = {sa, 8'hFF, 23'd0};
    else r = {sa, ex[7:0], mr[22:0]};
    return r;
  endfunction

endpackage

@@ hdl/transfer_matrix_accumulate_top.sv @@
// ----------------------------------------------------------------------------
// transfer_matrix_accumulate_top: running 2x2 complex products per wavelength
// Sequence: identity writes the identity matrices; multiply loads, forms products, sums them, then stores.
// A new input word is taken only in idle, after the previous result has been accepted at out_tready high.
// Reset: rst_n sync active low clears the sequencer; product memory not cleared.
// ----------------------------------------------------------------------------
module transfer_matrix_accumulate_top #(
  parameter int NUM_WAVELENGTHS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: wavelength_index[9:0], layer_s_a..layer_s_d, layer_p_a..layer_p_d
  //        (64 bits each from bit 10), zero fill to 528 bits
  input  logic [527:0] in_tdata,
  // tuser: operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: result_index[9:0], prod_s_a..prod_s_d, prod_p_a..prod_p_d
  //        (64 bits each from bit 10), zero fill to 528 bits
  output logic [527:0] out_tdata
);
  import tma_pkg::*;

  // index field is 10 bits wide, so no more than 1024 entries are reachable
  localparam int DW = (NUM_WAVELENGTHS > 1024) ? 10 :
                      (NUM_WAVELENGTHS > 1) ? $clog2(NUM_WAVELENGTHS) : 1;
  localparam int AW = DW + 3;
  localparam int MEM_DEPTH = 8 << DW;

  // memory: {p/s, index, element}
  logic [63:0] mem_r [MEM_DEPTH];
  logic [63:0] rd_r;

  state_t      state_r;
  logic        op_r;
  logic [9:0]  idx_r;
  logic [63:0] lay_r [8];
  logic [63:0] st_r  [8];   // loaded stored products, then new products
  logic [31:0] prd_r [32];  // real products
  logic [5:0]  cnt_r;
  logic        out_valid_r;

  logic [3:0]  ld_sel;
  logic [AW-1:0] addr;
  logic        idx_ok;

  assign idx_ok = {22'd0, in_tdata[9:0]} < NUM_WAVELENGTHS;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    ld_sel = cnt_r[3:0];
    addr = {ld_sel[2], idx_r[DW-1:0], ld_sel[1:0]};
  end

  // Multiply scheduling: cnt -> mat m (s/p), element e, product term j, part q
  logic [31:0] mul_a, mul_b;
  logic [2:0]  m_row, m_col;
  always_comb begin
    // cnt[5]=mat, cnt[4:3]=out element, cnt[2]=term, cnt[1:0]=part pair
    logic [1:0] e; logic t; logic [1:0] q;
    logic [63:0] x, y;
    e = cnt_r[4:3]; t = cnt_r[2]; q = cnt_r[1:0];
    m_row = {cnt_r[5], e[1], t};            // layer element x[2*row + t]
    m_col = {cnt_r[5], t, e[0]};            // stored element y[2*t + col]
    x = lay_r[m_row];
    y = st_r[m_col];
    unique case (q)
      2'd0: begin mul_a = x[63:32]; mul_b = y[63:32]; end
      2'd1: begin mul_a = x[31:0];  mul_b = y[31:0];  end
      2'd2: begin mul_a = x[63:32]; mul_b = y[31:0];  end
      default: begin mul_a = x[31:0]; mul_b = y[63:32]; end
    endcase
  end

  // Add schedule, six part sums per element: re/im of both terms into acc,
  // then term 0 + term 1 for re and im.
  logic [31:0] add_a, add_b, add_y;
  logic [31:0] acc_r [4];
  always_comb begin
    logic [4:0] b0, b1;
    b0 = {cnt_r[4:3], 3'b000};
    b1 = {cnt_r[4:3], 3'b100};
    add_a = '0; add_b = '0;
    unique case (cnt_r[2:0])
      3'd0: begin add_a = prd_r[b0 + 5'd0]; add_b = prd_r[b0 + 5'd1] ^ 32'h8000_0000; end
      3'd1: begin add_a = prd_r[b0 + 5'd2]; add_b = prd_r[b0 + 5'd3]; end
      3'd2: begin add_a = prd_r[b1 + 5'd0]; add_b = prd_r[b1 + 5'd1] ^ 32'h8000_0000; end
      3'd3: begin add_a = prd_r[b1 + 5'd2]; add_b = prd_r[b1 + 5'd3]; end
      3'd4: begin add_a = acc_r[0]; add_b = acc_r[2]; end
      default: begin add_a = acc_r[1]; add_b = acc_r[3]; end
    endcase
    add_y = fadd(add_a, add_b);
  end

  // Products for one matrix at a time: prd_r holds 32 slots per matrix pass.
  logic mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      mat_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && idx_ok) begin
            op_r <= in_tuser;
            idx_r <= in_tdata[9:0];
            for (int k = 0; k < 8; k++) lay_r[k] <= in_tdata[10 + 64*k +: 64];
            cnt_r <= '0;
            state_r <= (in_tuser == OP_MUL) ? ST_LOAD : ST_WRITE;
          end
        end
        ST_LOAD: begin
          rd_r <= mem_r[addr];
          if (cnt_r != 0) st_r[3'(cnt_r - 6'd1)] <= rd_r;
          if (cnt_r == 6'd8) begin
            cnt_r <= '0;
            mat_r <= 1'b0;
            state_r <= ST_MUL;
          end else cnt_r <= cnt_r + 6'd1;
        end
        ST_MUL: begin
          prd_r[cnt_r[4:0]] <= fmul(mul_a, mul_b);
          if (cnt_r[4:0] == 5'd31) begin
            cnt_r <= {mat_r, 5'd0};
            state_r <= ST_ADD;
          end else cnt_r <= cnt_r + 6'd1;
        end
        ST_ADD: begin
          if (cnt_r[2:0] < 3'd4) acc_r[cnt_r[1:0]] <= add_y;
          else if (cnt_r[2:0] == 3'd4) st_r[{mat_r, cnt_r[4:3]}][63:32] <= add_y;
          else st_r[{mat_r, cnt_r[4:3]}][31:0] <= add_y;
          if (cnt_r[2:0] == 3'd5) begin
            if (cnt_r[4:3] == 2'd3) begin
              if (!mat_r) begin
                mat_r <= 1'b1;
                cnt_r <= 6'b100000;
                state_r <= ST_MUL;
              end else begin
                cnt_r <= '0;
                state_r <= ST_WRITE;
              end
            end else cnt_r <= {cnt_r[5:3] + 3'd1, 3'd0};
          end else cnt_r <= cnt_r + 6'd1;
        end
        ST_WRITE: begin
          if (op_r == OP_IDENT) begin
            st_r[cnt_r[2:0]] <= (cnt_r[1:0] == 2'd0 || cnt_r[1:0] == 2'd3) ? ONE_PACKED : 64'd0;
          end
          if (cnt_r == 6'd8) begin
            out_valid_r <= 1'b1;
            state_r <= ST_OUT;
          end else cnt_r <= cnt_r + 6'd1;
        end
        default: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // memory write: in WRITE, one word per cycle, in the cycle after its value settles
  logic        wr_en;
  logic [2:0]  wr_sel;
  logic [63:0] wr_val;
  always_comb begin
    wr_en  = (state_r == ST_WRITE) && (cnt_r != 0);
    wr_sel = 3'(cnt_r - 6'd1);
    wr_val = st_r[wr_sel];
  end
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[{wr_sel[2], idx_r[DW-1:0], wr_sel[1:0]}] <= wr_val;
  end

  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[9:0] = idx_r;
    for (int k = 0; k < 8; k++) out_tdata[10 + 64*k +: 64] = st_r[k];
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == ST_OUT) else $error("result shown outside output state");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
`endif

endmodule
